### rtl/lts_pkg.sv
// lts_pkg: shared types and constants of the literal text match scanner
// no dependencies; used by every rtl file of the block but lts_stream_if via scoped names

package lts_pkg;

	// register map of the configuration port
	localparam int APB_ADDR_W   = 6;
	localparam int APB_DATA_W   = 64;
	localparam int REG_ADDR_LSB = 3;

	typedef enum logic [2:0] {
		REG_QUERY_LOW    = 3'd0,
		REG_QUERY_HIGH   = 3'd1,
		REG_QUERY_LENGTH = 3'd2,
		REG_EXACT_CASE   = 3'd3,
		REG_WORD_BOUND   = 3'd4,
		REG_MATCH_LIMIT  = 3'd5
	} cfg_reg_e;

	localparam logic [15:0] MATCH_LIMIT_RESET = 16'd2000;

	// query bytes held in the two query registers
	localparam int QUERY_REG_BYTES = 16;

	// character codes
	localparam logic [7:0] CHAR_LF         = 8'h0A;
	localparam logic [7:0] CHAR_CR         = 8'h0D;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

	// result queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		MODE_DATA = 1'b0,
		MODE_EOF  = 1'b1
	} mode_e;

	typedef struct packed {
		mode_e      mode;
		logic [7:0] data_byte;
	} text_item_t;

	typedef struct packed {
		logic [15:0] file_index;
		logic [23:0] line_number;
		logic [15:0] column;
		logic        limit_reached;
		logic        last_of_run;
	} hit_item_t;

	typedef struct packed {
		logic [63:0] query_low;
		logic [63:0] query_high;
		logic [4:0]  query_length;
		logic        exact_case;
		logic        word_bound;
		logic [15:0] match_limit;
	} cfg_t;

	// write strobes into the result queue, second only with first
	typedef struct packed {
		logic first;
		logic second;
	} qpush_t;

endpackage

### rtl/lts_stream_if.sv
// lts_stream_if: valid/ready channel with a typed payload
// payload type is supplied by the instantiating scope, usually from lts_pkg

interface lts_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### rtl/literal_text_match_scanner_top.sv
// literal_text_match_scanner_top: streaming literal search with line/column report
// depends on lts_pkg, lts_stream_if, lts_cfg_regs, lts_core, lts_result_queue
//
//  channel  role     payload        transfer when
//  text     sink     text_item_t    text.valid && text.ready
//  hits     source   hit_item_t     hits.valid && hits.ready
//  apb      slave    64-bit regs    psel && penable && pwrite && pready (write)
//
// one text item per cycle while the input stage is not held; each item passes the
// input register, and its results then enter a four-entry queue that drives hits
// the input stage moves on only while the queue has two free entries, so a stalled
// hits channel backs up into text
// asynchronous reset clears all search state and counters at once, no clearing pass

module literal_text_match_scanner_top #(
	parameter int MAX_QUERY_BYTES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lts_stream_if.sink                       text,
	lts_stream_if.source                     hits,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lts_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lts_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lts_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	lts_pkg::cfg_t                          cfg;
	lts_pkg::qpush_t                        q_push;
	lts_pkg::hit_item_t                     wr0, wr1;
	logic [lts_pkg::QUEUE_LVL_W-1:0]        q_level;

	// configuration registers
	lts_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// search datapath
	lts_core #(
		.MAX_QUERY_BYTES (MAX_QUERY_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.cfg     (cfg),
		.q_level (q_level),
		.q_push  (q_push),
		.wr0     (wr0),
		.wr1     (wr1)
	);

	// result queue
	lts_result_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.wr0     (wr0),
		.wr1     (wr1),
		.q_level (q_level),
		.hits    (hits)
	);

endmodule

### rtl/lts_cfg_regs.sv
// lts_cfg_regs: APB-style configuration registers of the scanner
// depends on lts_pkg for the register map and the cfg_t bundle

module lts_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lts_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lts_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lts_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output lts_pkg::cfg_t                    cfg
);

	logic                                                    wr_en;
	logic [lts_pkg::APB_ADDR_W-lts_pkg::REG_ADDR_LSB-1:0]    reg_idx;
	lts_pkg::cfg_t                                           cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[lts_pkg::APB_ADDR_W-1:lts_pkg::REG_ADDR_LSB];
	assign cfg     = cfg_q;

	// register writes in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.query_low    <= '0;
			cfg_q.query_high   <= '0;
			cfg_q.query_length <= '0;
			cfg_q.exact_case   <= 1'b0;
			cfg_q.word_bound   <= 1'b0;
			cfg_q.match_limit  <= lts_pkg::MATCH_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				lts_pkg::REG_QUERY_LOW:    cfg_q.query_low    <= pwdata;
				lts_pkg::REG_QUERY_HIGH:   cfg_q.query_high   <= pwdata;
				lts_pkg::REG_QUERY_LENGTH: cfg_q.query_length <= pwdata[4:0];
				lts_pkg::REG_EXACT_CASE:   cfg_q.exact_case   <= pwdata[0];
				lts_pkg::REG_WORD_BOUND:   cfg_q.word_bound   <= pwdata[0];
				lts_pkg::REG_MATCH_LIMIT:  cfg_q.match_limit  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			lts_pkg::REG_QUERY_LOW:    prdata = cfg_q.query_low;
			lts_pkg::REG_QUERY_HIGH:   prdata = cfg_q.query_high;
			lts_pkg::REG_QUERY_LENGTH: prdata = {59'd0, cfg_q.query_length};
			lts_pkg::REG_EXACT_CASE:   prdata = {63'd0, cfg_q.exact_case};
			lts_pkg::REG_WORD_BOUND:   prdata = {63'd0, cfg_q.word_bound};
			lts_pkg::REG_MATCH_LIMIT:  prdata = {48'd0, cfg_q.match_limit};
			default:                   prdata = '0;
		endcase
	end

endmodule

### rtl/lts_core.sv
// lts_core: input stage and single-pass search logic of the scanner
// depends on lts_pkg and lts_stream_if; writes results into lts_result_queue

module lts_core #(
	parameter int MAX_QUERY_BYTES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lts_stream_if.sink                          text,
	input  lts_pkg::cfg_t                       cfg,
	input  logic [lts_pkg::QUEUE_LVL_W-1:0]     q_level,
	output lts_pkg::qpush_t                     q_push,
	output lts_pkg::hit_item_t                  wr0,
	output lts_pkg::hit_item_t                  wr1
);

	// length width holds MAX_QUERY_BYTES + 1, window index width holds MAX_QUERY_BYTES
	localparam int LW  = $clog2(MAX_QUERY_BYTES + 2);
	localparam int WIW = (MAX_QUERY_BYTES > 1) ? $clog2(MAX_QUERY_BYTES + 1) : 1;
	localparam int QB  = (MAX_QUERY_BYTES < lts_pkg::QUERY_REG_BYTES) ?
		MAX_QUERY_BYTES : lts_pkg::QUERY_REG_BYTES;

	typedef struct packed {
		logic [MAX_QUERY_BYTES:0][7:0] win;
		logic [LW-1:0]                 bval;
		logic [15:0]                   col;
		logic [23:0]                   line;
		logic [15:0]                   file;
		logic [15:0]                   sfrom;
		logic                          pend_v;
		logic [15:0]                   pend_col;
		logic                          held_cr;
	} scan_st_t;

	// input stage
	logic                   text_v_s1;
	lts_pkg::text_item_t    text_s1;
	logic                   advance;

	// search state
	scan_st_t               st_q;
	scan_st_t               nxt;
	logic [15:0]            mcount_q;
	logic                   stopped_q;

	// static query view
	logic [lts_pkg::QUERY_REG_BYTES-1:0][7:0] qbytes;
	logic [LW-1:0]                            len_eff;
	logic [7:0]                               len_ext;
	logic [MAX_QUERY_BYTES-1:0][7:0]          aq_f;

	// match candidates in emission order
	logic [3:0]             c_v;
	logic [15:0]            c_col [4];
	logic                   sel0_v, sel1_v;
	logic [15:0]            sel0_col, sel1_col;
	logic                   e0, e1;
	logic                   lim0, lim1;
	logic [15:0]            cnt_nxt;
	logic                   stp_nxt;

	function automatic logic is_word(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || (c == lts_pkg::CHAR_UNDERSCORE);
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (!cfg.exact_case && c >= "A" && c <= "Z")
			return c + 8'd32;
		return c;
	endfunction

	function automatic logic window_eq(input logic [MAX_QUERY_BYTES:0][7:0] w);
		logic eq;
		eq = 1'b1;
		for (int j = 0; j < MAX_QUERY_BYTES; j++) begin
			if (8'(j) < len_ext && fold(w[j]) != aq_f[j])
				eq = 1'b0;
		end
		return eq;
	endfunction

	// one text byte into the window, with pending and new match candidates
	function automatic void do_push(
		inout  scan_st_t    s,
		input  logic [7:0]  b,
		output logic        a_v,
		output logic [15:0] a_col,
		output logic        n_v,
		output logic [15:0] n_col
	);
		logic [15:0] col_old;
		logic [15:0] start;
		logic        hit;
		a_v      = s.pend_v && !is_word(b);
		a_col    = s.pend_col;
		n_v      = 1'b0;
		n_col    = '0;
		s.pend_v = 1'b0;
		col_old  = s.col;
		s.win    = {s.win[MAX_QUERY_BYTES-1:0], b};
		if (s.bval != LW'(MAX_QUERY_BYTES + 1))
			s.bval = s.bval + LW'(1);
		if (s.col != 16'hFFFF)
			s.col = s.col + 16'd1;
		start = col_old + 16'd1 - 16'(len_eff);
		hit = (len_eff != '0) && (col_old != 16'hFFFF) && (s.bval >= len_eff) &&
			(start >= s.sfrom) && window_eq(s.win);
		if (hit) begin
			s.sfrom = col_old + 16'd1;
			if (cfg.word_bound) begin
				if (start == 16'd0 || !is_word(s.win[len_eff[WIW-1:0]])) begin
					s.pend_v   = 1'b1;
					s.pend_col = start;
				end
			end else begin
				n_v   = 1'b1;
				n_col = start;
			end
		end
	endfunction

	// line end: flush a pending match and clear the line state
	function automatic void end_line(
		inout  scan_st_t    s,
		output logic        a_v,
		output logic [15:0] a_col
	);
		a_v      = s.pend_v;
		a_col    = s.pend_col;
		s.pend_v   = 1'b0;
		s.pend_col = '0;
		s.win      = '0;
		s.bval     = '0;
		s.col      = '0;
		s.sfrom    = '0;
		if (s.line != 24'hFFFFFF)
			s.line = s.line + 24'd1;
	endfunction

	// effective length and query aligned to the window, folded
	always_comb begin
		qbytes  = {cfg.query_high, cfg.query_low};
		len_eff = ({3'b000, cfg.query_length} > 8'(MAX_QUERY_BYTES)) ?
			LW'(MAX_QUERY_BYTES) : LW'(cfg.query_length);
		len_ext = 8'(len_eff);
		for (int j = 0; j < MAX_QUERY_BYTES; j++) begin
			aq_f[j] = '0;
			for (int i = 0; i < QB; i++) begin
				if (8'(i + j + 1) == len_ext)
					aq_f[j] = fold(qbytes[i]);
			end
		end
	end

	// per-item state update and candidate collection
	always_comb begin
		nxt = st_q;
		c_v = '0;
		for (int k = 0; k < 4; k++)
			c_col[k] = '0;
		if (!stopped_q) begin
			unique case (text_s1.mode)
				lts_pkg::MODE_DATA: begin
					if (nxt.held_cr) begin
						nxt.held_cr = 1'b0;
						if (text_s1.data_byte == lts_pkg::CHAR_LF) begin
							end_line(nxt, c_v[0], c_col[0]);
						end else begin
							do_push(nxt, lts_pkg::CHAR_CR, c_v[0], c_col[0], c_v[1], c_col[1]);
							if (text_s1.data_byte == lts_pkg::CHAR_CR)
								nxt.held_cr = 1'b1;
							else
								do_push(nxt, text_s1.data_byte, c_v[2], c_col[2],
									c_v[3], c_col[3]);
						end
					end else begin
						priority if (text_s1.data_byte == lts_pkg::CHAR_CR) begin
							nxt.held_cr = 1'b1;
						end else if (text_s1.data_byte == lts_pkg::CHAR_LF) begin
							end_line(nxt, c_v[0], c_col[0]);
						end else begin
							do_push(nxt, text_s1.data_byte, c_v[0], c_col[0],
								c_v[1], c_col[1]);
						end
					end
				end
				lts_pkg::MODE_EOF: begin
					nxt.held_cr = 1'b0;
					end_line(nxt, c_v[0], c_col[0]);
					nxt.line = '0;
					if (nxt.file != 16'hFFFF)
						nxt.file = nxt.file + 16'd1;
				end
				default: ;
			endcase
		end
	end

	// first two candidates, then match count and stop
	always_comb begin
		sel0_v   = 1'b0;
		sel1_v   = 1'b0;
		sel0_col = '0;
		sel1_col = '0;
		for (int k = 0; k < 4; k++) begin
			if (c_v[k]) begin
				if (!sel0_v) begin
					sel0_v   = 1'b1;
					sel0_col = c_col[k];
				end else if (!sel1_v) begin
					sel1_v   = 1'b1;
					sel1_col = c_col[k];
				end
			end
		end
		cnt_nxt = mcount_q;
		stp_nxt = stopped_q;
		lim0    = 1'b0;
		lim1    = 1'b0;
		e0      = sel0_v && !stp_nxt;
		if (e0) begin
			if (cnt_nxt != 16'hFFFF)
				cnt_nxt = cnt_nxt + 16'd1;
			lim0    = (cnt_nxt >= cfg.match_limit);
			stp_nxt = lim0;
		end
		e1 = sel1_v && !stp_nxt;
		if (e1) begin
			if (cnt_nxt != 16'hFFFF)
				cnt_nxt = cnt_nxt + 16'd1;
			lim1    = (cnt_nxt >= cfg.match_limit);
			stp_nxt = lim1;
		end
	end

	// results toward the queue
	assign advance       = text_v_s1 &&
		(q_level <= lts_pkg::QUEUE_LVL_W'(lts_pkg::QUEUE_DEPTH - 2));
	assign text.ready    = !text_v_s1 || advance;
	assign q_push.first  = advance && e0;
	assign q_push.second = advance && e1;

	assign wr0.file_index    = st_q.file;
	assign wr0.line_number   = st_q.line;
	assign wr0.column        = sel0_col;
	assign wr0.limit_reached = lim0;
	assign wr0.last_of_run   = !e1;
	assign wr1.file_index    = st_q.file;
	assign wr1.line_number   = st_q.line;
	assign wr1.column        = sel1_col;
	assign wr1.limit_reached = lim1;
	assign wr1.last_of_run   = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_v_s1 <= 1'b0;
		end else if (text.ready) begin
			text_v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_s1 <= '0;
		end else if (text.valid && text.ready) begin
			text_s1 <= text.payload;
		end
	end

	// search state, updated as each item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '0;
			mcount_q  <= '0;
			stopped_q <= 1'b0;
		end else if (advance) begin
			st_q      <= nxt;
			mcount_q  <= cnt_nxt;
			stopped_q <= stp_nxt;
		end
	end

endmodule

### rtl/lts_result_queue.sv
// lts_result_queue: small result queue, up to two writes and one read per cycle
// depends on lts_pkg and lts_stream_if; drives the hits channel

module lts_result_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lts_pkg::qpush_t                     q_push,
	input  lts_pkg::hit_item_t                  wr0,
	input  lts_pkg::hit_item_t                  wr1,
	output logic [lts_pkg::QUEUE_LVL_W-1:0]     q_level,
	lts_stream_if.source                        hits
);

	lts_pkg::hit_item_t                     mem_q [lts_pkg::QUEUE_DEPTH];
	logic [lts_pkg::QUEUE_PTR_W-1:0]        head_q, tail_q;
	logic [lts_pkg::QUEUE_LVL_W-1:0]        count_q;
	logic                                   pop;
	logic [1:0]                             n_push;

	assign pop          = hits.valid && hits.ready;
	assign n_push       = {1'b0, q_push.first} + {1'b0, q_push.second};
	assign q_level      = count_q;
	assign hits.valid   = (count_q != '0);
	assign hits.payload = mem_q[head_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + lts_pkg::QUEUE_PTR_W'(n_push);
			head_q  <= head_q + lts_pkg::QUEUE_PTR_W'(pop);
			count_q <= count_q + lts_pkg::QUEUE_LVL_W'(n_push) - lts_pkg::QUEUE_LVL_W'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (q_push.first)
			mem_q[tail_q] <= wr0;
		if (q_push.second)
			mem_q[tail_q + lts_pkg::QUEUE_PTR_W'(1)] <= wr1;
	end

endmodule

### rtl/lts_checker.sv
// lts_checker: port-level assertions for the literal text match scanner
// depends on lts_pkg; bound to literal_text_match_scanner_top below

module lts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               text_ready,
	input logic               hits_valid,
	input logic               hits_ready,
	input lts_pkg::hit_item_t hits_payload
);

	// a stalled result holds
	a_hits_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hits_valid && !hits_ready |=> hits_valid && $stable(hits_payload))
		else $error("hits payload changed while stalled");

	// nothing follows the result that reaches the limit
	a_limit_last: assert property (@(posedge clk) disable iff (!arst_n)
		hits_valid && hits_ready && hits_payload.limit_reached |=> !hits_valid)
		else $error("result after the limit result");

	// the limit result closes its item
	a_limit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		hits_valid && hits_payload.limit_reached |-> hits_payload.last_of_run)
		else $error("limit result without last_of_run");

	// text only stalls behind waiting results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> hits_valid)
		else $error("text stalled with no result waiting");

endmodule

bind literal_text_match_scanner_top lts_checker u_lts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_ready   (text.ready),
	.hits_valid   (hits.valid),
	.hits_ready   (hits.ready),
	.hits_payload (hits.payload)
);

### test/literal_text_match_scanner_top_tb.sv
`timescale 1ns / 100ps
// literal_text_match_scanner_top_tb: self-checking bench for the literal text match scanner
// drives text items and register writes, predicts every hit and checks the hits channel
// depends on lts_pkg, lts_stream_if and literal_text_match_scanner_top

module literal_text_match_scanner_top_tb;

	localparam int QMAX         = 16;
	localparam int MAX_HITS     = 2;
	localparam int STALL_LIMIT  = 5000;
	localparam int SETTLE       = 4;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 148;
	localparam int IDLE_PCT     = 29;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [lts_pkg::APB_ADDR_W-1:0]   paddr;
	logic [lts_pkg::APB_DATA_W-1:0]   pwdata;
	logic [lts_pkg::APB_DATA_W-1:0]   prdata;
	logic                             pready;

	lts_stream_if #(.payload_t(lts_pkg::text_item_t)) text_ch ();
	lts_stream_if #(.payload_t(lts_pkg::hit_item_t))  hits_ch ();

	literal_text_match_scanner_top #(
		.MAX_QUERY_BYTES(QMAX)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.hits   (hits_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register copy and search state of the scanner model
	lts_pkg::cfg_t cfg_shadow;
	logic [7:0]    win [0:QMAX];
	logic [4:0]    line_fill;
	logic [15:0]   col_cnt;
	logic [23:0]   line_cnt;
	logic [15:0]   file_cnt;
	logic [15:0]   search_col;
	bit            pend_valid;
	logic [15:0]   pend_col;
	bit            cr_held;
	logic [15:0]   hit_count;
	bit            halted;

	lts_pkg::hit_item_t   step_hits[$];
	lts_pkg::hit_item_t   exp_hits[$];
	lts_pkg::text_item_t  tx_queue[$];

	bit          no_idle;
	bit          text_sent;
	int          err_cnt;
	int          quiet_cycles;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (!cfg_shadow.exact_case && c >= "A" && c <= "Z")
			return c + 8'd32;
		return c;
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == lts_pkg::CHAR_UNDERSCORE;
	endfunction

	function automatic logic [7:0] query_at(input int i);
		if (i < 8)
			return cfg_shadow.query_low[8*i +: 8];
		if (i < 16)
			return cfg_shadow.query_high[8*(i-8) +: 8];
		return 8'h00;
	endfunction

	// one reported match, dropped once halted or the item is full
	task automatic record_hit(input logic [15:0] col);
		lts_pkg::hit_item_t h;
		if (halted || step_hits.size() >= MAX_HITS)
			return;
		if (hit_count != 16'hFFFF)
			hit_count++;
		h.file_index    = file_cnt;
		h.line_number   = line_cnt;
		h.column        = col;
		h.limit_reached = (hit_count >= cfg_shadow.match_limit);
		h.last_of_run   = 1'b0;
		if (h.limit_reached)
			halted = 1'b1;
		step_hits.insert(step_hits.size(), h);
	endtask

	// one text byte into the line window
	task automatic scan_byte(input logic [7:0] b);
		int          qlen;
		int          i;
		logic [15:0] col;
		logic [15:0] start;
		bit          hit;
		qlen = (cfg_shadow.query_length > QMAX) ? QMAX : int'(cfg_shadow.query_length);
		col  = col_cnt;
		// right neighbour decides a held whole-word match
		if (pend_valid) begin
			pend_valid = 1'b0;
			if (!word_char(b))
				record_hit(pend_col);
		end
		for (i = QMAX; i > 0; i--)
			win[i] = win[i-1];
		win[0] = b;
		if (line_fill < QMAX + 1)
			line_fill++;
		if (col_cnt != 16'hFFFF)
			col_cnt++;
		if (qlen > 0 && col != 16'hFFFF && int'(line_fill) >= qlen) begin
			start = col + 16'd1 - 16'(qlen);
			hit   = (start >= search_col);
			for (i = 0; i < qlen; i++)
				if (fold_case(win[qlen-1-i]) != fold_case(query_at(i)))
					hit = 1'b0;
			if (hit) begin
				search_col = start + 16'(qlen);
				if (cfg_shadow.word_bound) begin
					if (start == 16'd0 || !word_char(win[qlen])) begin
						pend_valid = 1'b1;
						pend_col   = start;
					end
				end else begin
					record_hit(start);
				end
			end
		end
	endtask

	task automatic close_line();
		int i;
		if (pend_valid)
			record_hit(pend_col);
		pend_valid = 1'b0;
		pend_col   = 16'd0;
		for (i = 0; i <= QMAX; i++)
			win[i] = 8'h00;
		line_fill  = 5'd0;
		col_cnt    = 16'd0;
		search_col = 16'd0;
		if (line_cnt != 24'hFFFFFF)
			line_cnt++;
	endtask

	// expected hits of one accepted text item
	task automatic predict_item(input lts_pkg::text_item_t it);
		int                 i;
		lts_pkg::hit_item_t h;
		step_hits.delete();
		if (halted)
			return;
		if (it.mode == lts_pkg::MODE_DATA) begin
			if (cr_held) begin
				cr_held = 1'b0;
				if (it.data_byte == lts_pkg::CHAR_LF) begin
					close_line();
				end else begin
					scan_byte(lts_pkg::CHAR_CR);
					if (it.data_byte == lts_pkg::CHAR_CR)
						cr_held = 1'b1;
					else
						scan_byte(it.data_byte);
				end
			end else if (it.data_byte == lts_pkg::CHAR_CR) begin
				cr_held = 1'b1;
			end else if (it.data_byte == lts_pkg::CHAR_LF) begin
				close_line();
			end else begin
				scan_byte(it.data_byte);
			end
		end else begin
			cr_held = 1'b0;
			close_line();
			line_cnt = 24'd0;
			if (file_cnt != 16'hFFFF)
				file_cnt++;
		end
		for (i = 0; i < step_hits.size(); i++) begin
			h = step_hits[i];
			h.last_of_run = (i == step_hits.size() - 1);
			exp_hits.insert(exp_hits.size(), h);
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endtask

	// text driver: present the oldest pending item, hold it until transfer
	always @(negedge clk) begin
		if (text_ch.valid && !text_sent) begin
			// keep the item on the bus
		end else if (tx_queue.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
			text_ch.valid   <= 1'b1;
			text_ch.payload <= tx_queue[0];
		end else begin
			text_ch.valid   <= 1'b0;
			text_ch.payload <= lts_pkg::text_item_t'(9'($urandom));
		end
		text_sent = 1'b0;
	end

	// text transfer feeds the model
	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) begin
			predict_item(text_ch.payload);
			void'(tx_queue.pop_front());
			text_sent = 1'b1;
		end
	end

	// hits sink with random back-pressure
	always @(negedge clk)
		hits_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	// hits monitor
	always @(posedge clk) begin
		lts_pkg::hit_item_t want;
		if (hits_ch.valid && hits_ch.ready) begin
			if (exp_hits.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected hit, expected none, actual %p",
					$time, hits_ch.payload);
			end else begin
				want = exp_hits.pop_front();
				check_field("file_index", want.file_index, hits_ch.payload.file_index);
				check_field("line_number", want.line_number, hits_ch.payload.line_number);
				check_field("column", want.column, hits_ch.payload.column);
				check_field("limit_reached", want.limit_reached,
					hits_ch.payload.limit_reached);
				check_field("last_of_run", want.last_of_run, hits_ch.payload.last_of_run);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (hits_ch.valid && hits_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input lts_pkg::cfg_reg_e idx, input logic [63:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lts_pkg::APB_ADDR_W'(int'(idx) << lts_pkg::REG_ADDR_LSB);
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		unique case (idx)
			lts_pkg::REG_QUERY_LOW:    cfg_shadow.query_low    = val;
			lts_pkg::REG_QUERY_HIGH:   cfg_shadow.query_high   = val;
			lts_pkg::REG_QUERY_LENGTH: cfg_shadow.query_length = val[4:0];
			lts_pkg::REG_EXACT_CASE:   cfg_shadow.exact_case   = val[0];
			lts_pkg::REG_WORD_BOUND:   cfg_shadow.word_bound   = val[0];
			lts_pkg::REG_MATCH_LIMIT:  cfg_shadow.match_limit  = val[15:0];
			default: ;
		endcase
	endtask

	// sender pause until every pending item and expected hit is gone
	task automatic wait_drained();
		do
			@(negedge clk);
		while (tx_queue.size() != 0 || exp_hits.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		lts_pkg::text_item_t it;
		it.mode      = lts_pkg::MODE_DATA;
		it.data_byte = b;
		tx_queue.insert(tx_queue.size(), it);
	endtask

	task automatic add_eof();
		lts_pkg::text_item_t it;
		it.mode      = lts_pkg::MODE_EOF;
		it.data_byte = 8'($urandom_range(255));
		tx_queue.insert(tx_queue.size(), it);
	endtask

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic set_search(input logic [127:0] qbits, input logic [4:0] qlen,
			input bit exact, input bit words);
		write_reg(lts_pkg::REG_QUERY_LOW, qbits[63:0]);
		write_reg(lts_pkg::REG_QUERY_HIGH, qbits[127:64]);
		write_reg(lts_pkg::REG_QUERY_LENGTH, 64'(qlen));
		write_reg(lts_pkg::REG_EXACT_CASE, 64'(exact));
		write_reg(lts_pkg::REG_WORD_BOUND, 64'(words));
	endtask

	function automatic bit is_letter(input logic [7:0] c);
		return (c | 8'h20) >= "a" && (c | 8'h20) <= "z";
	endfunction

	// query bytes from a small alphabet so that overlaps and case folding show up
	function automatic logic [7:0] pick_query_byte();
		int r;
		r = $urandom_range(99);
		if (r < 30) return "a";
		if (r < 50) return "b";
		if (r < 60) return "A";
		if (r < 68) return "B";
		if (r < 75) return lts_pkg::CHAR_UNDERSCORE;
		if (r < 80) return " ";
		if (r < 84) return lts_pkg::CHAR_CR;
		if (r < 87) return "0";
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_text_byte(input int eff);
		int          r;
		logic [7:0]  c;
		logic [31:0] letters;
		letters = "abAB";
		r = $urandom_range(99);
		if (r < 35 && eff > 0) begin
			c = query_at($urandom_range(eff - 1));
			if (is_letter(c) && $urandom_range(1))
				c ^= 8'h20;
			return c;
		end
		if (r < 55) return letters[8*$urandom_range(3) +: 8];
		if (r < 65) return " ";
		if (r < 70) return lts_pkg::CHAR_UNDERSCORE;
		if (r < 74) return 8'("0" + $urandom_range(9));
		if (r < 79) return lts_pkg::CHAR_CR;
		if (r < 84) return lts_pkg::CHAR_LF;
		if (r < 87) return "-";
		return 8'($urandom_range(255));
	endfunction

	initial begin
		logic [127:0] qbits;
		logic [4:0]   qlen_cfg;
		logic [7:0]   c;
		int           eff;
		int           p;
		int           n;
		int           i;
		int           r;

		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		text_ch.valid   = 1'b0;
		text_ch.payload = '0;
		hits_ch.ready   = 1'b0;
		no_idle         = 1'b0;
		text_sent       = 1'b0;
		err_cnt         = 0;
		quiet_cycles    = 0;

		cfg_shadow.query_low    = '0;
		cfg_shadow.query_high   = '0;
		cfg_shadow.query_length = '0;
		cfg_shadow.exact_case   = 1'b0;
		cfg_shadow.word_bound   = 1'b0;
		cfg_shadow.match_limit  = lts_pkg::MATCH_LIMIT_RESET;
		for (i = 0; i <= QMAX; i++)
			win[i] = 8'h00;
		line_fill  = '0;
		col_cnt    = '0;
		line_cnt   = '0;
		file_cnt   = '0;
		search_col = '0;
		pend_valid = 1'b0;
		pend_col   = '0;
		cr_held    = 1'b0;
		hit_count  = '0;
		halted     = 1'b0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: folded whole-word query with line edges, lone and trailing cr
		qbits = {$urandom, $urandom, $urandom, $urandom};
		qbits[15:0] = 16'h6241;
		set_search(qbits, 5'd2, 1'b0, 1'b1);
		write_reg(lts_pkg::REG_MATCH_LIMIT, 64'hFFFF);
		add_text("AB abc-ab");
		add_byte(lts_pkg::CHAR_CR);
		add_byte(lts_pkg::CHAR_LF);
		add_byte(8'hFF);
		add_text("ab");
		add_byte(8'h00);
		add_text("ab");
		add_byte(lts_pkg::CHAR_CR);
		add_eof();
		add_text("ab");
		add_byte(lts_pkg::CHAR_CR);
		add_text("ab");
		add_byte(lts_pkg::CHAR_LF);

		// random phases, each with its own search setting
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: qlen_cfg = 5'd0;
				1: qlen_cfg = 5'd16;
				2: qlen_cfg = 5'd31;
				3: qlen_cfg = 5'd17;
				default: qlen_cfg = ($urandom_range(99) < 80) ?
					5'($urandom_range(4, 1)) : 5'($urandom_range(16, 5));
			endcase
			eff   = (qlen_cfg > QMAX) ? QMAX : int'(qlen_cfg);
			qbits = {$urandom, $urandom, $urandom, $urandom};
			for (i = 0; i < eff; i++)
				qbits[8*i +: 8] = pick_query_byte();
			wait_drained();
			no_idle = 1'b0;
			if (p == 4)
				set_search(qbits, qlen_cfg, 1'b1, 1'b1);
			else if (p == 5)
				set_search(qbits, qlen_cfg, 1'b0, 1'b0);
			else
				set_search(qbits, qlen_cfg, 1'($urandom), 1'($urandom));
			if (p == 3)
				write_reg(lts_pkg::REG_MATCH_LIMIT, 64'(lts_pkg::MATCH_LIMIT_RESET));
			if (p == 6)
				write_reg(lts_pkg::REG_MATCH_LIMIT, 64'hFFFF);
			no_idle = (p == 7);
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 15 && eff > 0) begin
					// planted occurrence with random case
					for (i = 0; i < eff; i++) begin
						c = query_at(i);
						if (is_letter(c) && $urandom_range(1))
							c ^= 8'h20;
						add_byte(c);
					end
					n += eff;
				end else if (r < 17) begin
					add_eof();
					n++;
				end else begin
					add_byte(pick_text_byte(eff));
					n++;
				end
			end
		end

		// limit: first of two hits in one item stops the block, later items ignored
		wait_drained();
		no_idle = 1'b0;
		qbits = {$urandom, $urandom, $urandom, $urandom};
		qbits[7:0] = lts_pkg::CHAR_CR;
		set_search(qbits, 5'd1, 1'b0, 1'b1);
		write_reg(lts_pkg::REG_MATCH_LIMIT, 64'd1);
		add_byte(lts_pkg::CHAR_LF);
		add_byte(" ");
		add_byte(lts_pkg::CHAR_CR);
		add_byte(lts_pkg::CHAR_CR);
		add_byte(" ");
		for (i = 0; i < 40; i++)
			add_byte(pick_text_byte(1));

		do
			@(negedge clk);
		while (tx_queue.size() != 0 || exp_hits.size() != 0);
		repeat (20) @(negedge clk);

		if (err_cnt == 0 && exp_hits.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
